### rtl/core/chr_pkg.sv
// shared constants, types and hash mixer step for the consistent hash ring
// no dependencies
package chr_pkg;

  localparam int unsigned MaxServers = 512;
  localparam int unsigned RingDepth  = 3 * MaxServers;
  localparam int unsigned AddrW      = $clog2(RingDepth);
  localparam int unsigned CountW     = $clog2(RingDepth + 1);
  localparam int unsigned PosW       = 32;
  localparam int unsigned SrvW       = 17;
  localparam int unsigned StrideW    = 20;
  localparam logic [31:0] MixMult    = 32'h045d9f3b;
  localparam int unsigned MixShift   = 16;
  localparam logic [StrideW-1:0] StrideReset = 20'd100000;

  localparam logic [1:0] FuncLookup = 2'd0;
  localparam logic [1:0] FuncAdd    = 2'd1;
  localparam logic [1:0] FuncRemove = 2'd2;
  localparam logic [1:0] FuncUnused = 2'd3;

  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatEmpty  = 2'd1;
  localparam logic [1:0] StatFull   = 2'd2;
  localparam logic [1:0] StatAbsent = 2'd3;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [SrvW-1:0] srv;
  } entry_t;

  // request to the hash mixer
  typedef struct packed {
    logic        start;
    logic [31:0] label;
  } mix_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] hash;
  } mix_rsp_t;

  function automatic logic [31:0] xs(input logic [31:0] x);
    return (x >> MixShift) ^ x;
  endfunction

endpackage

### rtl/core/chr_mixer.sv
// multi-cycle xor-shift-multiply hash mixer, one multiply per cycle
// depends on chr_pkg
module chr_mixer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  chr_pkg::mix_req_t req_i,
  output chr_pkg::mix_rsp_t rsp_o
);

  logic [31:0] val_q, val_d;
  logic [1:0]  step_q, step_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;

  // one shared multiplier applied twice
  always_comb begin
    val_d  = val_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      val_d  = req_i.label;
      step_d = 2'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (step_q == 2'd2) begin
        val_d  = chr_pkg::xs(val_q);
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        val_d  = chr_pkg::xs(val_q) * chr_pkg::MixMult;
        step_d = step_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.hash = val_q;

endmodule

### rtl/core/chr_ram.sv
// ring entry store with one write port and one registered read port
// depends on chr_pkg
module chr_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [chr_pkg::AddrW-1:0]  waddr_i,
  input  chr_pkg::entry_t            wdata_i,
  input  logic [chr_pkg::AddrW-1:0]  raddr_i,
  output chr_pkg::entry_t            rdata_o
);

  chr_pkg::entry_t mem_q [chr_pkg::RingDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/consistent_hash_ring.sv
// top level of the consistent hash ring: sequencer over the entry memory
// depends on chr_pkg, chr_mixer, chr_ram
//
// Every transaction is handled alone; s_axis_tready is low until its result
// has been taken. A lookup scans the sorted ring one entry at a time, reading
// and then checking each entry. A remove compacts the ring in one pass. An add
// hashes each of three labels, scans to the insertion point and then shifts
// the ring tail down by one entry, reading and then writing each one. Positions
// are sorted ascending, ties ordered by server number.
module consistent_hash_ring (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [19:0] cfg_wdata_i,   // replica_stride
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // func[1:0], server_number[18:2], key[50:19]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // owner_server[16:0], status[18:17], ring_count[29:19]
);

  localparam int unsigned AW = chr_pkg::AddrW;
  localparam int unsigned CW = chr_pkg::CountW;

  typedef enum logic [3:0] {
    StIdle, StLkRd, StLkChk, StHash, StFind, StFindChk, StShRd, StShWr,
    StIns, StRmRd, StRmChk, StOut
  } state_e;

  state_e state_q;
  logic [chr_pkg::StrideW-1:0] stride_q;
  logic [CW-1:0] count_q;
  logic [1:0]  func_q;
  logic [chr_pkg::SrvW-1:0] srv_q;
  logic [31:0] key_q;
  logic [CW-1:0] idx_q, wr_q;
  logic [1:0]  k_q;
  logic [31:0] pos_q;
  logic        found_q;
  logic [chr_pkg::SrvW-1:0] owner_q, first_q;
  logic [1:0]  stat_q;
  logic [31:0] label_q;

  // memory port
  logic we;
  logic [AW-1:0] waddr, raddr;
  chr_pkg::entry_t wdata, rdata;
  chr_pkg::mix_req_t mreq;
  chr_pkg::mix_rsp_t mrsp;

  chr_ram u_ram (.clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
                 .raddr_i(raddr), .rdata_o(rdata));
  chr_mixer u_mix (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata = {2'b00, count_q[CW-1:0], stat_q, owner_q};

  // memory and mixer drive
  always_comb begin
    we = 1'b0;
    waddr = idx_q[AW-1:0];
    wdata = '{pos: pos_q, srv: srv_q};
    raddr = idx_q[AW-1:0];
    mreq.start = 1'b0;
    mreq.label = label_q;
    case (state_q)
      StShRd: raddr = AW'(idx_q - CW'(1));
      StShWr: begin
        we = 1'b1;
        wdata = rdata;
      end
      StIns:  we = 1'b1;
      StRmChk: begin
        waddr = wr_q[AW-1:0];
        wdata = rdata;
        we = (rdata.srv != srv_q);
      end
      StHash: mreq.start = !found_q;
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      stride_q <= chr_pkg::StrideReset;
      count_q  <= '0;
      found_q  <= 1'b0;
    end else begin
      if (cfg_we_i) stride_q <= cfg_wdata_i;
      case (state_q)
        StIdle: if (in_fire) begin
          func_q  <= s_axis_tdata[1:0];
          srv_q   <= s_axis_tdata[18:2];
          key_q   <= s_axis_tdata[50:19];
          owner_q <= '0;
          stat_q  <= chr_pkg::StatOk;
          idx_q   <= '0;
          wr_q    <= '0;
          k_q     <= 2'd0;
          found_q <= 1'b0;
          label_q <= 32'(s_axis_tdata[18:2]);
          case (s_axis_tdata[1:0])
            chr_pkg::FuncLookup: begin
              if (count_q == '0) begin
                stat_q <= chr_pkg::StatEmpty;
                state_q <= StOut;
              end else state_q <= StLkRd;
            end
            chr_pkg::FuncAdd: begin
              if (32'(count_q) + 32'd3 > 32'(chr_pkg::RingDepth)) begin
                stat_q <= chr_pkg::StatFull;
                state_q <= StOut;
              end else state_q <= StHash;
            end
            chr_pkg::FuncRemove: begin
              if (count_q == '0) begin
                stat_q <= chr_pkg::StatAbsent;
                state_q <= StOut;
              end else state_q <= StRmRd;
            end
            default: state_q <= StOut;
          endcase
        end
        // lookup: read then check each entry
        StLkRd: state_q <= StLkChk;
        StLkChk: begin
          if (idx_q == '0) first_q <= rdata.srv;
          if (rdata.pos >= key_q) begin
            owner_q <= rdata.srv;
            state_q <= StOut;
          end else if (idx_q + CW'(1) == count_q) begin
            owner_q <= (idx_q == '0) ? rdata.srv : first_q;
            state_q <= StOut;
          end else begin
            idx_q <= idx_q + CW'(1);
            state_q <= StLkRd;
          end
        end
        // add: hash the label, wait for mixer
        StHash: begin
          found_q <= 1'b1;
          if (mrsp.done) begin
            pos_q <= mrsp.hash;
            found_q <= 1'b0;
            idx_q <= '0;
            if (count_q == '0) state_q <= StIns;
            else state_q <= StFind;
          end
        end
        StFind: state_q <= StFindChk;
        StFindChk: begin
          if (rdata.pos < pos_q || (rdata.pos == pos_q && rdata.srv <= srv_q)) begin
            if (idx_q + CW'(1) == count_q) begin
              idx_q <= count_q;
              state_q <= StIns;
            end else begin
              idx_q <= idx_q + CW'(1);
              state_q <= StFind;
            end
          end else begin
            wr_q <= idx_q;
            idx_q <= count_q;
            state_q <= StShRd;
          end
        end
        // shift tail down one entry from the top
        StShRd: state_q <= StShWr;
        StShWr: begin
          if (idx_q - CW'(1) == wr_q) state_q <= StIns;
          else state_q <= StShRd;
          idx_q <= idx_q - CW'(1);
        end
        StIns: begin
          count_q <= count_q + CW'(1);
          k_q <= k_q + 2'd1;
          label_q <= label_q + 32'(stride_q);
          if (k_q == 2'd2) state_q <= StOut;
          else state_q <= StHash;
        end
        // remove: compact the ring in place
        StRmRd: state_q <= StRmChk;
        StRmChk: begin
          if (rdata.srv != srv_q) wr_q <= wr_q + CW'(1);
          else found_q <= 1'b1;
          if (idx_q + CW'(1) == count_q) begin
            count_q <= (rdata.srv != srv_q) ? wr_q + CW'(1) : wr_q;
            if (!(found_q || rdata.srv == srv_q)) stat_q <= chr_pkg::StatAbsent;
            state_q <= StOut;
          end else begin
            idx_q <= idx_q + CW'(1);
            state_q <= StRmRd;
          end
        end
        StOut: if (m_axis_tready) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  logic unused_func;
  assign unused_func = ^{func_q, s_axis_tdata[55:51]};

endmodule
